// File: hdl/mon9_pkg.sv
// shared types, constants and compare-exchange helper for the median-of-nine pipeline
package mon9_pkg;

    localparam int PIX_W = 8;
    localparam int N_PIX = 9;
    localparam int IDX_W = $clog2(N_PIX);

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [N_PIX-1:0] pix_vec_t;

    // order one pair so that entry lo holds the smaller value
    function automatic pix_vec_t cas(input pix_vec_t v, input int lo, input int hi);
        pix_vec_t r;
        r = v;
        if (v[lo[IDX_W-1:0]] > v[hi[IDX_W-1:0]])
        begin
            r[lo[IDX_W-1:0]] = v[hi[IDX_W-1:0]];
            r[hi[IDX_W-1:0]] = v[lo[IDX_W-1:0]];
        end
        return r;
    endfunction

endpackage

// File: hdl/mon9_sort3.sv
// first pipeline stage: sorts the three triples of samples
module mon9_sort3
    import mon9_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_vec_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_vec_t out_data
);

    logic     valid_reg;
    pix_vec_t data_reg;
    pix_vec_t data_next;

    // three compare layers, each sorting within the triples
    always_comb
    begin
        data_next = in_data;
        data_next = cas(data_next, 1, 2);
        data_next = cas(data_next, 4, 5);
        data_next = cas(data_next, 7, 8);
        data_next = cas(data_next, 0, 1);
        data_next = cas(data_next, 3, 4);
        data_next = cas(data_next, 6, 7);
        data_next = cas(data_next, 1, 2);
        data_next = cas(data_next, 4, 5);
        data_next = cas(data_next, 7, 8);
    end

    // stage may load when empty or when its item moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // each triple leaves this stage in ascending order
    a_triples_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg[0] <= data_reg[1]) && (data_reg[1] <= data_reg[2]) &&
                      (data_reg[3] <= data_reg[4]) && (data_reg[4] <= data_reg[5]) &&
                      (data_reg[6] <= data_reg[7]) && (data_reg[7] <= data_reg[8]))
        else $error("mon9_sort3: triple not sorted");

endmodule

// File: hdl/mon9_merge.sv
// second pipeline stage: combines the sorted triples toward the middle three
module mon9_merge
    import mon9_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_vec_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_vec_t out_data
);

    logic     valid_reg;
    pix_vec_t data_reg;
    pix_vec_t data_next;

    // column maxima/minima, then the first step of the final chain
    always_comb
    begin
        data_next = in_data;
        data_next = cas(data_next, 0, 3);
        data_next = cas(data_next, 5, 8);
        data_next = cas(data_next, 4, 7);
        data_next = cas(data_next, 3, 6);
        data_next = cas(data_next, 1, 4);
        data_next = cas(data_next, 2, 5);
        data_next = cas(data_next, 4, 7);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // ordering set up by this stage
    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg[3] <= data_reg[6]) && (data_reg[4] <= data_reg[7]))
        else $error("mon9_merge: merge ordering broken");

endmodule

// File: hdl/mon9_select.sv
// third pipeline stage: median of the three remaining candidates, output register
module mon9_select
    import mon9_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_vec_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_t     out_data
);

    logic     valid_reg;
    pix_t     median_reg;
    pix_vec_t work;
    pix_t     median_next;

    // median of entries two, four and six lands in entry four
    always_comb
    begin
        work        = in_data;
        work        = cas(work, 4, 2);
        work        = cas(work, 6, 4);
        work        = cas(work, 4, 2);
        median_next = work[4];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            median_reg <= median_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = median_reg;

endmodule

// File: hdl/median_of_nine_pixels_top.sv
// Median of nine 8-bit samples: each item on the slave side carries nine pixels and yields one
// item on the master side holding their fifth smallest value. The work runs through a
// three-stage compare-exchange network (sort triples, merge, select); an item is registered
// in each stage in turn before it shows up on the master side, and one item can be accepted
// every cycle while m_tready is high or a stage holds a bubble.
// Each stage holds one item; tready on the slave side follows m_tready combinationally through
// the three stages, and it is high whenever any stage holds a bubble. No state persists
// between items and there are no registers to configure.
module median_of_nine_pixels_top
    import mon9_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [N_PIX*PIX_W-1:0] s_tdata,   // pix_0, pix_1, ..., pix_8 from bit 0 up
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PIX_W-1:0]       m_tdata    // median_value
);

    pix_vec_t in_vec;
    pix_vec_t a_data;
    pix_vec_t b_data;
    pix_t     median;
    logic     a_valid;
    logic     a_ready;
    logic     b_valid;
    logic     b_ready;

    // pix_0 sits in the lowest byte, matching packed index 0
    assign in_vec = pix_vec_t'(s_tdata);

    mon9_sort3 u_sort3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_vec),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_data  (a_data)
    );

    mon9_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    mon9_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_data   (b_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (median)
    );

    assign m_tdata = median;

    // a draining or empty output never blocks the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("top: input stalled while output drains");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("top: input stalled with empty output stage");

endmodule

// File: tb/median_of_nine_pixels_top_tb.sv
// self-checking testbench for the median-of-nine pixel pipeline
module median_of_nine_pixels_top_tb;
    import mon9_pkg::*;

    localparam int RANDOM_ITEMS = 590;
    localparam int CALM_ITEMS   = 120;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 12;
    localparam int RUN_LIMIT    = 2000000;

    // keeps the medians still owed by the block, oldest first
    class median_scoreboard;
        pix_t owed_medians[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // fifth smallest by rank counting
        function pix_t fifth_smallest(pix_vec_t v);
            int below;
            int at_or_below;
            fifth_smallest = '0;
            for (int i = 0; i < N_PIX; i++)
            begin
                below = 0;
                at_or_below = 0;
                for (int j = 0; j < N_PIX; j++)
                begin
                    if (v[j] < v[i])
                        below++;
                    if (v[j] <= v[i])
                        at_or_below++;
                end
                if (below <= 4 && at_or_below > 4)
                    fifth_smallest = v[i];
            end
        endfunction

        function void note_input(pix_vec_t v);
            owed_medians.push_back(fifth_smallest(v));
        endfunction

        function void check_result(pix_t got);
            pix_t want;
            if (owed_medians.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %0d", $time, got);
                errors++;
            end
            else
            begin
                want = owed_medians.pop_front();
                if (got !== want)
                begin
                    $display("%0t: median_value expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [N_PIX*PIX_W-1:0] s_tdata;    // pix_0, pix_1, ..., pix_8 from bit 0 up
    logic                   m_tvalid;
    logic                   m_tready;
    logic [PIX_W-1:0]       m_tdata;    // median_value

    median_scoreboard sb;
    bit               calm;
    bit               hold_req;

    median_of_nine_pixels_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #RUN_LIMIT;
        $display("median_of_nine_pixels_top: mismatch");
        $finish;
    end

    // both handshakes, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // offer one item and hold it until accepted
    task automatic send_item(input pix_vec_t v);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drop valid for a few cycles, with junk on the data lines
    task automatic pause_input(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= (N_PIX*PIX_W)'({$urandom, $urandom, $urandom});
        repeat (cycles) @(posedge clk);
    endtask

    // random pixel set: uniform, clustered for ties, or extremes only
    function automatic pix_vec_t random_pixels();
        pix_vec_t v;
        int       style;
        int       base;
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 252);
        for (int i = 0; i < N_PIX; i++)
        begin
            case (style)
                0, 1: v[i] = pix_t'($urandom_range(0, 255));
                2: v[i] = pix_t'(base + $urandom_range(0, 3));
                default: v[i] = $urandom_range(0, 1) ? pix_t'($urandom_range(252, 255))
                                                     : pix_t'($urandom_range(0, 3));
            endcase
        end
        return v;
    endfunction

    // receiver: random stalls, one long hold-off on request, none at the end
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        pix_vec_t v;
        int       lower;
        int       waited;

        sb       = new();
        calm     = 1'b0;
        hold_req = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, orderings, ties and bit patterns
        send_item({N_PIX{8'h00}});
        send_item({N_PIX{8'hFF}});
        send_item({N_PIX{8'h80}});
        for (int i = 0; i < N_PIX; i++)
            v[i] = pix_t'(i * 30);
        send_item(v);
        for (int i = 0; i < N_PIX; i++)
            v[i] = pix_t'(255 - i * 30);
        send_item(v);
        for (int i = 0; i < N_PIX; i++)
            v[i] = (i < 5) ? 8'h00 : 8'hFF;
        send_item(v);
        for (int i = 0; i < N_PIX; i++)
            v[i] = (i < 4) ? 8'h00 : 8'hFF;
        send_item(v);
        for (int i = 0; i < N_PIX; i++)
            v[i] = i[0] ? 8'h55 : 8'hAA;
        send_item(v);
        for (int i = 0; i < N_PIX; i++)
            v[i] = i[0] ? 8'hAA : 8'h55;
        send_item(v);
        pause_input($urandom_range(1, 11));
        // unique median placed at each position in turn
        for (int k = 0; k < N_PIX; k++)
        begin
            lower = 0;
            for (int i = 0; i < N_PIX; i++)
            begin
                if (i == k)
                    v[i] = 8'd100;
                else
                begin
                    v[i] = (lower < 4) ? pix_t'(10 + lower * 20) : pix_t'(160 + lower * 10);
                    lower++;
                end
            end
            send_item(v);
        end
        // ties around the median
        v = {8'd7, 8'd3, 8'd3, 8'd9, 8'd3, 8'd1, 8'd3, 8'd250, 8'd3};
        send_item(v);
        v = {8'd254, 8'd1, 8'd254, 8'd1, 8'd254, 8'd1, 8'd254, 8'd1, 8'd128};
        send_item(v);

        // random part with gaps on both sides
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                // receiver holds off while items keep coming back to back
                hold_req = 1'b1;
                for (int b = 0; b < 40; b++)
                    send_item(random_pixels());
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                pause_input($urandom_range(1, 11));
            send_item(random_pixels());
        end
        s_tvalid <= 1'b0;

        // drain
        waited = 0;
        while (sb.owed_medians.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.owed_medians.size() == 0)
            $display("median_of_nine_pixels_top: match");
        else
            $display("median_of_nine_pixels_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
hdl/mon9_pkg.sv
hdl/mon9_sort3.sv
hdl/mon9_merge.sv
hdl/mon9_select.sv
hdl/median_of_nine_pixels_top.sv
tb/median_of_nine_pixels_top_tb.sv
